FILE: rtl/core/wds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wds_pkg
// shared types and constants of the weighted destination sampler
// ---------------------------------------------------------------------------
package wds_pkg;

    localparam int ROW_W  = 6;
    localparam int WVAL_W = 16;
    localparam int DRAW_W = 16;
    localparam int TP_W   = 17;
    localparam int CIU_W  = 7;
    localparam int CFG_W  = 17;
    localparam int BIT_W  = 4;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_TRAVEL_PROB = 1'b0;
    localparam logic CFG_CITIES      = 1'b1;

    // one classified word waiting for the back end
    typedef struct packed {
        logic              is_sample;
        logic              go;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [WVAL_W-1:0] wval;
        logic [DRAW_W-1:0] where_draw;
    } t_qent;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_GOAL,
        ST_SEARCH
    } t_bstate;

endpackage

FILE: rtl/core/wds_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wds_front
// accepts command words, classifies them and queues them for the back end
// ---------------------------------------------------------------------------
module wds_front #(
    parameter int CITY_COUNT = 64,
    parameter int CNT_W      = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [wds_pkg::ROW_W-1:0]    i_source_city,
    input  logic [wds_pkg::ROW_W-1:0]    i_target_column,
    input  logic [wds_pkg::WVAL_W-1:0]   i_weight_value,
    input  logic [wds_pkg::DRAW_W-1:0]   i_stay_draw,
    input  logic [wds_pkg::DRAW_W-1:0]   i_where_draw,
    input  logic [wds_pkg::TP_W-1:0]     i_travel_prob,
    input  logic [CNT_W-1:0]             i_span,
    output logic                         o_q_vld,
    output wds_pkg::t_qent               o_q_ent,
    input  logic                         i_q_pop
);
    import wds_pkg::*;

    t_qent              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    t_qent              cls;
    logic               push;
    logic               pop;
    logic               row_ok;
    logic               col_ok;

    assign row_ok = int'(i_source_city) < CITY_COUNT;
    assign col_ok = int'(i_target_column) < CITY_COUNT;

    always_comb begin
        cls.is_sample  = (i_opcode == OP_SAMPLE);
        cls.row        = i_source_city;
        cls.col        = i_target_column;
        cls.wval       = i_weight_value;
        cls.where_draw = i_where_draw;
        if (i_opcode == OP_SAMPLE) begin
            cls.go = ({1'b0, i_stay_draw} < i_travel_prob) && row_ok && (i_span != '0);
        end else begin
            cls.go = row_ok && col_ok;
        end
    end

    assign busy    = (r_cnt == QCNT_W'(QDEPTH)) || !i_rst_n;
    assign push    = start && !busy;
    assign pop     = i_q_pop && o_q_vld;
    assign o_q_vld = (r_cnt != '0);
    assign o_q_ent = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

FILE: rtl/core/wds_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wds_back
// weight table and cumulative weight search, one queued word at a time
// ---------------------------------------------------------------------------
module wds_back #(
    parameter int CITY_COUNT  = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int CNT_W       = 7
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [CNT_W-1:0]             i_span,
    input  logic                         i_q_vld,
    input  wds_pkg::t_qent               i_q_ent,
    output logic                         o_q_pop,
    output logic                         o_valid,
    output logic [wds_pkg::ROW_W-1:0]    o_destination_city,
    output logic                         o_travelled
);
    import wds_pkg::*;

    localparam int DEPTH  = CITY_COUNT * CITY_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SUM_W  = WEIGHT_BITS + CNT_W;
    localparam int GOAL_W = SUM_W + DRAW_W;

    logic [WEIGHT_BITS-1:0] mem [DEPTH];

    t_bstate                r_state, n_state;
    t_qent                  r_cur, n_cur;
    logic [CNT_W-1:0]       r_iss, n_iss;
    logic                   r_rvld, n_rvld;
    logic [CNT_W-1:0]       r_rcol, n_rcol;
    logic [WEIGHT_BITS-1:0] r_rdata;
    logic [SUM_W-1:0]       r_total, n_total;
    logic [SUM_W-1:0]       r_run, n_run;
    logic [GOAL_W-1:0]      r_addend, n_addend;
    logic [GOAL_W-1:0]      r_goal, n_goal;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic                   r_done, n_done;
    logic [ROW_W-1:0]       r_dest, n_dest;
    logic                   r_went, n_went;

    logic                   we;
    logic [ADDR_W-1:0]      wa;
    logic [WEIGHT_BITS-1:0] wd;
    logic                   rd_en;
    logic [ADDR_W-1:0]      rd_addr;
    logic [SUM_W-1:0]       run_sum;
    logic [CNT_W-1:0]       last_col;

    assign wa       = ADDR_W'(i_q_ent.row) * ADDR_W'(CITY_COUNT) + ADDR_W'(i_q_ent.col);
    assign wd       = WEIGHT_BITS'(i_q_ent.wval);
    assign rd_addr  = ADDR_W'(r_cur.row) * ADDR_W'(CITY_COUNT) + ADDR_W'(r_iss);
    assign run_sum  = r_run + SUM_W'(r_rdata);
    assign last_col = i_span - CNT_W'(1);

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_iss    = r_iss;
        n_rvld   = 1'b0;
        n_rcol   = r_rcol;
        n_total  = r_total;
        n_run    = r_run;
        n_addend = r_addend;
        n_goal   = r_goal;
        n_bit    = r_bit;
        n_done   = 1'b0;
        n_dest   = r_dest;
        n_went   = 1'b0;
        o_q_pop  = 1'b0;
        we       = 1'b0;
        rd_en    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_iss   = '0;
                n_total = '0;
                if (i_q_vld) begin
                    o_q_pop = 1'b1;
                    n_cur   = i_q_ent;
                    if (!i_q_ent.is_sample) begin
                        we = i_q_ent.go;
                    end else if (!i_q_ent.go) begin
                        n_done = 1'b1;
                        n_dest = i_q_ent.row;
                    end else begin
                        n_state = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (r_iss < i_span) begin
                    rd_en  = 1'b1;
                    n_rvld = 1'b1;
                    n_rcol = r_iss;
                    n_iss  = r_iss + 1'b1;
                end
                if (r_rvld) begin
                    n_total = r_total + SUM_W'(r_rdata);
                    if (r_rcol == last_col) begin
                        n_state  = ST_GOAL;
                        n_rvld   = 1'b0;
                        n_bit    = '0;
                        n_goal   = '0;
                        n_addend = GOAL_W'(n_total);
                    end
                end
            end
            ST_GOAL: begin
                if (r_total == '0) begin
                    n_done  = 1'b1;
                    n_dest  = r_cur.row;
                    n_state = ST_IDLE;
                end else begin
                    if (r_cur.where_draw[r_bit]) begin
                        n_goal = r_goal + r_addend;
                    end
                    n_addend = r_addend << 1;
                    n_bit    = r_bit + 1'b1;
                    if (r_bit == BIT_W'(DRAW_W - 1)) begin
                        n_state = ST_SEARCH;
                        n_iss   = '0;
                        n_run   = '0;
                    end
                end
            end
            ST_SEARCH: begin
                if (r_iss < i_span) begin
                    rd_en  = 1'b1;
                    n_rvld = 1'b1;
                    n_rcol = r_iss;
                    n_iss  = r_iss + 1'b1;
                end
                if (r_rvld) begin
                    n_run = run_sum;
                    if (r_rdata != '0 && (GOAL_W'(run_sum) << DRAW_W) >= r_goal) begin
                        n_done  = 1'b1;
                        n_went  = 1'b1;
                        n_dest  = ROW_W'(r_rcol);
                        n_state = ST_IDLE;
                    end else if (r_rcol == last_col) begin
                        n_done  = 1'b1;
                        n_dest  = r_cur.row;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rvld  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rvld  <= n_rvld;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_iss    <= n_iss;
        r_rcol   <= n_rcol;
        r_total  <= n_total;
        r_run    <= n_run;
        r_addend <= n_addend;
        r_goal   <= n_goal;
        r_bit    <= n_bit;
        r_dest   <= n_dest;
        r_went   <= n_went;
    end

    // weight table
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    assign o_valid            = r_done;
    assign o_destination_city = r_dest;
    assign o_travelled        = r_went;

endmodule

FILE: rtl/core/weighted_destination_sampler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_destination_sampler
// picks a destination city by cumulative weight over one row of a table
// ---------------------------------------------------------------------------
// A command word is taken at a clock edge with start high and busy low.
// Opcode 0 stores one weight, opcode 1 samples a destination. Words pass a
// two-entry queue into the back end, so busy is high while it is full or
// while reset is held. A write gives no result. A sample that does not
// draw travel needs no table read; its result is registered as the back
// end pops it. One that draws travel totals the row through the single
// table read port, span being the columns searched, and stays home at once
// when the total is zero; otherwise a shift-add over the where draw bits
// forms the scaled target and a second walk searches the row. Each result
// is shown for one cycle with o_valid high; the receiver cannot stall it.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must do so only while the block is idle, as the block has no
// guard for it. Synchronous reset clears the queue, the sequencer and the
// registers (travel probability 0, 64 cities in use); the weight table is
// not cleared and rows must be written before they are sampled.
// ---------------------------------------------------------------------------
module weighted_destination_sampler #(
    parameter int CITY_COUNT  = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [wds_pkg::ROW_W-1:0]    i_source_city,
    input  logic [wds_pkg::ROW_W-1:0]    i_target_column,
    input  logic [wds_pkg::WVAL_W-1:0]   i_weight_value,
    input  logic [wds_pkg::DRAW_W-1:0]   i_stay_draw,
    input  logic [wds_pkg::DRAW_W-1:0]   i_where_draw,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [wds_pkg::CFG_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    output logic [wds_pkg::ROW_W-1:0]    o_destination_city,
    output logic                         o_travelled
);
    import wds_pkg::*;

    localparam int CNT_W = $clog2(CITY_COUNT + 1);

    logic [TP_W-1:0]  r_travel_prob;
    logic [CIU_W-1:0] r_cities_in_use;
    logic [CNT_W-1:0] span;
    logic             q_vld;
    t_qent            q_ent;
    logic             q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_travel_prob   <= '0;
            r_cities_in_use <= CIU_W'(64);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TRAVEL_PROB: r_travel_prob   <= i_cfg_data[TP_W-1:0];
                CFG_CITIES:      r_cities_in_use <= i_cfg_data[CIU_W-1:0];
                default:         r_travel_prob   <= r_travel_prob;
            endcase
        end
    end

    // search saturates at the table width
    assign span = (int'(r_cities_in_use) > CITY_COUNT) ? CNT_W'(CITY_COUNT)
                                                        : CNT_W'(r_cities_in_use);

    wds_front #(
        .CITY_COUNT (CITY_COUNT),
        .CNT_W      (CNT_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_source_city   (i_source_city),
        .i_target_column (i_target_column),
        .i_weight_value  (i_weight_value),
        .i_stay_draw     (i_stay_draw),
        .i_where_draw    (i_where_draw),
        .i_travel_prob   (r_travel_prob),
        .i_span          (span),
        .o_q_vld         (q_vld),
        .o_q_ent         (q_ent),
        .i_q_pop         (q_pop)
    );

    wds_back #(
        .CITY_COUNT  (CITY_COUNT),
        .WEIGHT_BITS (WEIGHT_BITS),
        .CNT_W       (CNT_W)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_span             (span),
        .i_q_vld            (q_vld),
        .i_q_ent            (q_ent),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .o_destination_city (o_destination_city),
        .o_travelled        (o_travelled)
    );

endmodule

FILE: verif/tb_weighted_destination_sampler.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_weighted_destination_sampler
// self-checking bench for the weighted destination sampler
// ---------------------------------------------------------------------------
// Eight whole rows of the weight table are loaded first and every sample
// uses one of them, so no sample can touch an entry that was never written.
// A short directed set then covers the edge cases: all-zero rows, skipped
// zero weights, draws of 0 and full scale, travel probability at zero, at
// full scale and above it, and a city count of zero, one and above the
// table size. After that come random phases, each with its own register
// settings and sender idle rate; random writes may land in any row. The
// driver predicts every accepted sample word from its own copy of the table
// and registers. The monitor checks each strobed result against the oldest
// prediction.
// ---------------------------------------------------------------------------
module tb_weighted_destination_sampler;
    import wds_pkg::*;

    localparam int CITIES        = 64;
    localparam int LOADED_ROWS   = 8;
    localparam int SETTLE_CYCLES = 160;
    localparam int PHASE_WORDS   = 60;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic              op;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [WVAL_W-1:0] wval;
        logic [DRAW_W-1:0] stay;
        logic [DRAW_W-1:0] where;
    } t_cmd;

    typedef struct packed {
        logic [ROW_W-1:0] dest;
        logic             went;
    } t_trip;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_opcode = OP_WRITE;
    logic [ROW_W-1:0]  i_source_city = '0;
    logic [ROW_W-1:0]  i_target_column = '0;
    logic [WVAL_W-1:0] i_weight_value = '0;
    logic [DRAW_W-1:0] i_stay_draw = '0;
    logic [DRAW_W-1:0] i_where_draw = '0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = CFG_TRAVEL_PROB;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              o_valid;
    logic [ROW_W-1:0]  o_destination_city;
    logic              o_travelled;

    logic [WVAL_W-1:0] weight_mem [CITIES][CITIES];
    logic [TP_W-1:0]   leave_threshold = '0;
    logic [CIU_W-1:0]  city_span = 7'd64;

    t_cmd  pending_cmds [$];
    t_trip expected_trips [$];
    t_cmd  cur_cmd;
    int    sender_idle_pct = 0;
    bit    drain_hold = 1'b0;
    int    samples_sent = 0;
    int    results_seen = 0;
    int    error_count = 0;

    weighted_destination_sampler dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_opcode           (i_opcode),
        .i_source_city      (i_source_city),
        .i_target_column    (i_target_column),
        .i_weight_value     (i_weight_value),
        .i_stay_draw        (i_stay_draw),
        .i_where_draw       (i_where_draw),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .o_destination_city (o_destination_city),
        .o_travelled        (o_travelled)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_trip predict_trip(input t_cmd c);
        t_trip           t;
        int              span;
        longint unsigned total;
        longint unsigned run;
        longint unsigned goal;
        longint unsigned w;
        bit              found;
        t.dest = c.row;
        t.went = 1'b0;
        total  = 0;
        run    = 0;
        found  = 1'b0;
        if ({1'b0, c.stay} < leave_threshold) begin
            span = (city_span > CITIES) ? CITIES : int'(city_span);
            for (int k = 0; k < span; k++) begin
                total += weight_mem[c.row][k];
            end
            if (total != 0) begin
                goal = total * c.where;
                for (int k = 0; k < span; k++) begin
                    w = weight_mem[c.row][k];
                    if (!found) begin
                        run += w;
                        if (w != 0 && (run << 16) >= goal) begin
                            t.dest = ROW_W'(k);
                            t.went = 1'b1;
                            found  = 1'b1;
                        end
                    end
                end
            end
        end
        return t;
    endfunction

    function automatic void take_cmd(input t_cmd c);
        if (c.op == OP_WRITE) begin
            weight_mem[c.row][c.col] = c.wval;
        end else begin
            expected_trips.push_back(predict_trip(c));
            samples_sent++;
        end
    endfunction

    // rows that are loaded in full: the lowest four and the highest four
    function automatic int loaded_row(input int i);
        return (i < 4) ? i : CITIES - LOADED_ROWS + i;
    endfunction

    function automatic t_cmd make_write(input int row, input int col, input int w);
        t_cmd c;
        c.op    = OP_WRITE;
        c.row   = ROW_W'(row);
        c.col   = ROW_W'(col);
        c.wval  = WVAL_W'(w);
        c.stay  = DRAW_W'($urandom);
        c.where = DRAW_W'($urandom);
        return c;
    endfunction

    function automatic t_cmd make_sample(input int row, input int stay, input int where);
        t_cmd c;
        c.op    = OP_SAMPLE;
        c.row   = ROW_W'(row);
        c.col   = ROW_W'($urandom);
        c.wval  = WVAL_W'($urandom);
        c.stay  = DRAW_W'(stay);
        c.where = DRAW_W'(where);
        return c;
    endfunction

    function automatic int pick16();
        case ($urandom_range(7))
            0: return 0;
            1: return 16'hFFFF;
            default: return int'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        if ($urandom_range(3) == 0) begin
            return make_write($urandom_range(CITIES - 1), $urandom_range(CITIES - 1), pick16());
        end
        return make_sample(loaded_row(int'($urandom_range(LOADED_ROWS - 1))),
                           pick16(), pick16());
    endfunction

    // driver: one word in flight on the command port at a time
    always @(posedge i_clk) begin : drv
        logic present;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            present = 1'b0;
            if (start) begin
                take_cmd(cur_cmd);
            end
            if (drain_hold && samples_sent == results_seen) begin
                drain_hold = 1'b0;
            end
            if (!drain_hold && pending_cmds.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct) begin
                cur_cmd = pending_cmds.pop_front();
                present = 1'b1;
                if ($urandom_range(79) == 0) begin
                    drain_hold = 1'b1;
                end
            end
            start <= present;
            if (present) begin
                i_opcode        <= cur_cmd.op;
                i_source_city   <= cur_cmd.row;
                i_target_column <= cur_cmd.col;
                i_weight_value  <= cur_cmd.wval;
                i_stay_draw     <= cur_cmd.stay;
                i_where_draw    <= cur_cmd.where;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : mon
        t_trip want;
        if (i_rst_n && o_valid) begin
            results_seen <= results_seen + 1;
            if (expected_trips.size() == 0) begin
                $display("%0t: unexpected result dest %0d travelled %0d",
                         $time, o_destination_city, o_travelled);
                error_count++;
            end else begin
                want = expected_trips.pop_front();
                if (o_destination_city !== want.dest) begin
                    $display("%0t: destination_city expected %0d got %0d",
                             $time, want.dest, o_destination_city);
                    error_count++;
                end
                if (o_travelled !== want.went) begin
                    $display("%0t: travelled expected %0d got %0d",
                             $time, want.went, o_travelled);
                    error_count++;
                end
            end
        end
    end

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pending_cmds.size() != 0 || start || samples_sent != results_seen);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input int val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        if (idx == CFG_CITIES) begin
            i_cfg_data <= {10'($urandom), 7'(val)};
            city_span = 7'(val);
        end else begin
            i_cfg_data <= 17'(val);
            leave_threshold = 17'(val);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_regs(input int prob, input int cities);
        wait_drained();
        write_reg(CFG_TRAVEL_PROB, prob);
        write_reg(CFG_CITIES, cities);
    endtask

    initial begin : main
        int kind;
        int w;
        int r;
        int idle_of [RANDOM_PHASES];
        int prob_of [RANDOM_PHASES];
        int span_of [RANDOM_PHASES];
        idle_of = '{0, 77, 9, 0, 77, 9};
        prob_of = '{65536, -1, 40000, 131071, 50000, -1};
        span_of = '{64, -1, 17, 127, 1, 64};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // load every entry of the sampled rows
        for (int i = 0; i < LOADED_ROWS; i++) begin
            r = loaded_row(i);
            kind = (i < 4) ? i + 10 : int'($urandom_range(9));
            for (int c = 0; c < CITIES; c++) begin
                case (kind)
                    10: w = 0;
                    11: w = (c == CITIES - 1) ? 1 : 0;
                    12: w = 16'hFFFF;
                    13: w = (c == 0) ? 0 : int'($urandom_range(1, 16'hFFFF));
                    0: w = 0;
                    1, 2, 3: w = ($urandom_range(7) == 0) ? int'($urandom_range(16'hFFFF)) : 0;
                    4, 5, 6: w = int'($urandom_range(16'hFFFF));
                    7: w = int'($urandom_range(3));
                    default: w = $urandom_range(1) ? 16'hFFFF : 0;
                endcase
                pending_cmds.push_back(make_write(r, c, w));
            end
        end

        // directed part
        set_regs(65536, 64);
        pending_cmds.push_back(make_sample(0, 0, 16'h8000));
        pending_cmds.push_back(make_sample(1, 16'hFFFF, 0));
        pending_cmds.push_back(make_sample(1, 0, 16'hFFFF));
        pending_cmds.push_back(make_sample(2, 0, 0));
        pending_cmds.push_back(make_sample(2, 16'hFFFF, 16'hFFFF));
        pending_cmds.push_back(make_sample(2, 16'h1234, 16'h8000));
        pending_cmds.push_back(make_sample(3, 0, 0));
        pending_cmds.push_back(make_write(63, 63, 16'hFFFF));
        pending_cmds.push_back(make_write(63, 0, 0));
        pending_cmds.push_back(make_sample(63, 0, 16'hFFFF));
        pending_cmds.push_back(make_sample(63, 0, 0));
        set_regs(0, 64);
        pending_cmds.push_back(make_sample(2, 0, 16'h8000));
        set_regs(131071, 64);
        pending_cmds.push_back(make_sample(2, 16'hFFFF, 16'h8000));
        set_regs(16'h8000, 64);
        pending_cmds.push_back(make_sample(2, 16'h7FFF, 0));
        pending_cmds.push_back(make_sample(2, 16'h8000, 0));
        set_regs(65536, 0);
        pending_cmds.push_back(make_sample(2, 0, 16'hFFFF));
        set_regs(65536, 1);
        pending_cmds.push_back(make_sample(2, 0, 16'hFFFF));
        pending_cmds.push_back(make_sample(3, 0, 0));
        pending_cmds.push_back(make_sample(1, 0, 0));
        set_regs(65536, 127);
        pending_cmds.push_back(make_sample(2, 0, 16'hFFFF));
        pending_cmds.push_back(make_sample(1, 0, 16'h4000));

        // random phases
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_regs((prob_of[p] < 0) ? int'($urandom_range(65536)) : prob_of[p],
                     (span_of[p] < 0) ? int'($urandom_range(1, 64)) : span_of[p]);
            sender_idle_pct = idle_of[p];
            for (int i = 0; i < PHASE_WORDS; i++) begin
                pending_cmds.push_back(random_cmd());
            end
        end

        wait_drained();
        if (expected_trips.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_trips.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_weighted_destination_sampler: done, clean");
        end else begin
            $display("tb_weighted_destination_sampler: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("tb_weighted_destination_sampler: done, errors");
        $finish;
    end

endmodule
